FILE: hdl/scatter_gather_copy_planner_defines.svh
// Assertion macros for the scatter-gather copy planner.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SCATTER_GATHER_COPY_PLANNER_DEFINES_SVH
`define SCATTER_GATHER_COPY_PLANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SGCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sgcp_pkg.sv
// Shared constants, codes and types of the scatter-gather copy planner.
// Depends on nothing.
package sgcp_pkg;

  localparam int MAX_DESC    = 16;
  localparam int CHUNK_BYTES = 4096;
  localparam int MAX_SEGS    = 31;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 13;
  localparam int TOT_W  = 20;
  localparam int KIND_W = 2;

  localparam int IDX_W = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int CNT_W = $clog2(MAX_DESC + 1);
  localparam int SEG_W = $clog2(MAX_SEGS + 1);

  localparam logic [KIND_W-1:0] KIND_SRC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

endpackage

FILE: hdl/sgcp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sgcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/scatter_gather_copy_planner.sv
// Scatter-gather copy planner: append requests keep busy low.
// A start request passes through ST_SKIP, one skipped source descriptor at a time, then
// ST_WALK, which emits one segment per cycle through the registered outputs.
// A degenerate start (empty list, zero count) answers next cycle; an offset past the end answers from ST_SKIP.
// The rate is set by one read of each descriptor RAM per cycle. The receiver cannot stall.
// rst clears the list counts, drop flag and sequencer; RAM contents stay undefined.
module scatter_gather_copy_planner
  import sgcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind,
  input  logic [ADDR_W-1:0] desc_addr,
  input  logic [LEN_W-1:0]  desc_len,
  input  logic [TOT_W-1:0]  start_offset,
  input  logic [TOT_W-1:0]  byte_count,
  output logic              seg_strobe,
  output logic [ADDR_W-1:0] seg_src_addr,
  output logic [ADDR_W-1:0] seg_dst_addr,
  output logic [LEN_W-1:0]  seg_len,
  output logic [TOT_W-1:0]  copied_total,
  output logic              overflow,
  output logic              last
);

`include "scatter_gather_copy_planner_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_WALK
  } state_t;

  state_t state, state_next;

  // List fill counts and walk position. The RAM read address always follows
  // the next index, so src_q/dst_q hold the entry at si/di in every cycle.
  logic [CNT_W-1:0] src_used, src_used_next;
  logic [CNT_W-1:0] dst_used, dst_used_next;
  logic             dropped, dropped_next;
  logic [CNT_W-1:0] si, si_next;
  logic [CNT_W-1:0] di, di_next;
  logic [LEN_W-1:0] spos, spos_next;
  logic [LEN_W-1:0] dpos, dpos_next;
  logic [TOT_W-1:0] offset, offset_next;
  logic [TOT_W-1:0] count, count_next;
  logic [TOT_W-1:0] total, total_next;
  logic [SEG_W-1:0] nseg, nseg_next;

  logic              strobe_next;
  logic [ADDR_W-1:0] seg_src_addr_next;
  logic [ADDR_W-1:0] seg_dst_addr_next;
  logic [LEN_W-1:0]  seg_len_next;
  logic [TOT_W-1:0]  copied_total_next;
  logic              overflow_next;
  logic              last_next;

  desc_t src_q, dst_q;
  desc_t wdesc;
  logic  accept;
  logic  src_we, dst_we;
  logic [LEN_W-1:0] len_sat;

  // Append path: drop zero-length chunks and chunks beyond a full list, clamp oversized ones.
  assign accept  = start && !busy;
  assign len_sat = (desc_len > LEN_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES) : desc_len;
  assign wdesc   = '{addr: desc_addr, len: len_sat};
  assign src_we  = accept && (kind == KIND_SRC) && (desc_len != '0) &&
                   (src_used < CNT_W'(MAX_DESC));
  assign dst_we  = accept && (kind == KIND_DST) && (desc_len != '0) &&
                   (dst_used < CNT_W'(MAX_DESC));

  sgcp_ram #(.WIDTH(DESC_W), .DEPTH(MAX_DESC)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_used[IDX_W-1:0]),
    .wdata (wdesc),
    .raddr (si_next[IDX_W-1:0]),
    .rdata (src_q)
  );

  sgcp_ram #(.WIDTH(DESC_W), .DEPTH(MAX_DESC)) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_used[IDX_W-1:0]),
    .wdata (wdesc),
    .raddr (di_next[IDX_W-1:0]),
    .rdata (dst_q)
  );

  // Walk datapath: segment is the least of source rest, destination rest
  // and bytes still owed.
  logic [LEN_W-1:0] srem, drem, mrem, seg;
  logic [TOT_W-1:0] crem, tot_add;
  logic [LEN_W-1:0] spos_add, dpos_add;
  logic [SEG_W-1:0] nseg_add;
  logic [CNT_W-1:0] si_inc, di_inc;
  logic             s_end, d_end, seg_last;

  always_comb begin
    srem     = src_q.len - spos;
    drem     = dst_q.len - dpos;
    crem     = count - total;
    mrem     = (srem < drem) ? srem : drem;
    seg      = (TOT_W'(mrem) < crem) ? mrem : crem[LEN_W-1:0];
    tot_add  = total + TOT_W'(seg);
    spos_add = spos + seg;
    dpos_add = dpos + seg;
    nseg_add = nseg + SEG_W'(1);
    si_inc   = si + CNT_W'(1);
    di_inc   = di + CNT_W'(1);
    s_end    = (spos_add == src_q.len);
    d_end    = (dpos_add == dst_q.len);
    // Stored lengths are never zero, so the walk ends right after this
    // segment exactly when a limit is hit or a list runs out here.
    seg_last = (tot_add == count) || (nseg_add == SEG_W'(MAX_SEGS)) ||
               (s_end && (si_inc >= src_used)) || (d_end && (di_inc >= dst_used));
  end

  always_comb begin
    state_next        = state;
    src_used_next     = src_used;
    dst_used_next     = dst_used;
    dropped_next      = dropped;
    si_next           = si;
    di_next           = di;
    spos_next         = spos;
    dpos_next         = dpos;
    offset_next       = offset;
    count_next        = count;
    total_next        = total;
    nseg_next         = nseg;
    strobe_next       = 1'b0;
    seg_src_addr_next = seg_src_addr;
    seg_dst_addr_next = seg_dst_addr;
    seg_len_next      = seg_len;
    copied_total_next = copied_total;
    overflow_next     = overflow;
    last_next         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (kind == KIND_SRC || kind == KIND_DST) begin
            if (desc_len != '0) begin
              if (kind == KIND_SRC) begin
                if (src_we) src_used_next = src_used + CNT_W'(1);
                else        dropped_next  = 1'b1;
              end else begin
                if (dst_we) dst_used_next = dst_used + CNT_W'(1);
                else        dropped_next  = 1'b1;
              end
            end
          end else if (kind == KIND_START) begin
            if (src_used == '0 || dst_used == '0 || byte_count == '0) begin
              // Nothing to copy: answer with one empty final segment.
              strobe_next       = 1'b1;
              seg_src_addr_next = '0;
              seg_dst_addr_next = '0;
              seg_len_next      = '0;
              copied_total_next = '0;
              overflow_next     = dropped;
              last_next         = 1'b1;
              src_used_next     = '0;
              dst_used_next     = '0;
              dropped_next      = 1'b0;
            end else begin
              si_next     = '0;
              di_next     = '0;
              dpos_next   = '0;
              offset_next = start_offset;
              count_next  = byte_count;
              total_next  = '0;
              nseg_next   = '0;
              state_next  = ST_SKIP;
            end
          end else begin
            // Unused kind: drop the request.
          end
        end
      end

      ST_SKIP: begin
        // Advance past whole source descriptors that lie before the offset.
        if (offset >= TOT_W'(src_q.len)) begin
          offset_next = offset - TOT_W'(src_q.len);
          si_next     = si_inc;
          if (si_inc >= src_used) begin
            strobe_next       = 1'b1;
            seg_src_addr_next = '0;
            seg_dst_addr_next = '0;
            seg_len_next      = '0;
            copied_total_next = '0;
            overflow_next     = dropped;
            last_next         = 1'b1;
            src_used_next     = '0;
            dst_used_next     = '0;
            dropped_next      = 1'b0;
            state_next        = ST_IDLE;
          end
        end else begin
          spos_next  = offset[LEN_W-1:0];
          state_next = ST_WALK;
        end
      end

      ST_WALK: begin
        strobe_next       = 1'b1;
        seg_src_addr_next = src_q.addr + ADDR_W'(spos);
        seg_dst_addr_next = dst_q.addr + ADDR_W'(dpos);
        seg_len_next      = seg;
        copied_total_next = tot_add;
        overflow_next     = dropped;
        last_next         = seg_last;
        total_next        = tot_add;
        nseg_next         = nseg_add;
        if (s_end) begin
          si_next   = si_inc;
          spos_next = '0;
        end else begin
          spos_next = spos_add;
        end
        if (d_end) begin
          di_next   = di_inc;
          dpos_next = '0;
        end else begin
          dpos_next = dpos_add;
        end
        if (seg_last) begin
          src_used_next = '0;
          dst_used_next = '0;
          dropped_next  = 1'b0;
          state_next    = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= 1'b0;
      src_used   <= '0;
      dst_used   <= '0;
      dropped    <= 1'b0;
      si         <= '0;
      di         <= '0;
      seg_strobe <= 1'b0;
      last       <= 1'b0;
    end else begin
      state      <= state_next;
      busy       <= (state_next != ST_IDLE);
      src_used   <= src_used_next;
      dst_used   <= dst_used_next;
      dropped    <= dropped_next;
      si         <= si_next;
      di         <= di_next;
      seg_strobe <= strobe_next;
      last       <= last_next;
    end
    spos         <= spos_next;
    dpos         <= dpos_next;
    offset       <= offset_next;
    count        <= count_next;
    total        <= total_next;
    nseg         <= nseg_next;
    seg_src_addr <= seg_src_addr_next;
    seg_dst_addr <= seg_dst_addr_next;
    seg_len      <= seg_len_next;
    copied_total <= copied_total_next;
    overflow     <= overflow_next;
  end

  // A final segment leaves both lists empty and the block idle.
  `SGCP_ASSERT_NOW(a_last_clears, seg_strobe && last, !busy && src_used == '0 && dst_used == '0, "lists not cleared after final segment")
  // A segment that is not final comes from a walk still in progress.
  `SGCP_ASSERT_NOW(a_mid_busy, seg_strobe && !last, busy && seg_len != '0, "non-final segment without walk")
  // The walk only ever points at stored descriptors.
  `SGCP_ASSERT_NOW(a_walk_idx, state == ST_WALK, si < src_used && di < dst_used, "walk index beyond list")
  // A start request with work to do raises busy on the next cycle.
  `SGCP_ASSERT_NEXT(a_start_busy, accept && kind == KIND_START && src_used != '0 && dst_used != '0 && byte_count != '0, busy, "start did not begin a walk")

endmodule
